### hdl/ordered_set_table_unit_macros.svh
// ============================================================================
// Ordered set table assertion macros
// Shared concurrent assertion forms for the ordered set table unit.
// ============================================================================
`ifndef ORDERED_SET_TABLE_UNIT_MACROS_SVH
`define ORDERED_SET_TABLE_UNIT_MACROS_SVH

// check the consequent in the same cycle as the antecedent
`define OST_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered set table assertion failed");

// check the consequent in the cycle after the antecedent
`define OST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered set table assertion failed");

`endif

### hdl/ost_pkg.sv
// ============================================================================
// Ordered set table package
// Widths, command and status codes, and controller/datapath interface types.
// ============================================================================
package ost_pkg;

    localparam int OST_SET_CAPACITY = 16;
    localparam int KEY_W            = 32;
    localparam int CMD_W            = 2;
    localparam int POS_W            = 4;
    localparam int COUNT_W          = 5;
    localparam int STATUS_W         = 2;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_ABSENT    = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic load_item;
        logic do_search;
        logic do_apply;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

### hdl/ost_ctrl.sv
// ============================================================================
// Ordered set table controller
// Sequences each transfer through a search step and an apply step.
// ============================================================================
module ost_ctrl
    import ost_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  dp_status_t dp_status,
    output ctl_cmd_t   ctl_cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_APPLY  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   apply_go;

    always_comb
    begin
        apply_go  = (state_reg == S_APPLY) && dp_status.out_free;
        cmd_stall = !((state_reg == S_IDLE) || apply_go);
        accept    = cmd_valid && !cmd_stall;

        ctl_cmd.load_item = accept;
        ctl_cmd.do_search = (state_reg == S_SEARCH);
        ctl_cmd.do_apply  = apply_go;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (apply_go)
                begin
                    state_next = accept ? S_SEARCH : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/ost_datapath.sv
// ============================================================================
// Ordered set table datapath
// Key storage with parallel match, compaction on remove, and result register.
// ============================================================================
module ost_datapath
    import ost_pkg::*;
#(
    parameter int SET_CAPACITY = OST_SET_CAPACITY
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctl_cmd_t                  ctl_cmd,
    output dp_status_t                dp_status,
    input  logic [CMD_W-1:0]          cmd,
    input  logic signed [KEY_W-1:0]   key,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic                      found,
    output logic [POS_W-1:0]          position,
    output logic [COUNT_W-1:0]        entry_count,
    output logic [STATUS_W-1:0]       status
);

    `include "ordered_set_table_unit_macros.svh"

    localparam int IDX_W  = $clog2(SET_CAPACITY);
    localparam int CNT_W  = $clog2(SET_CAPACITY + 1);
    localparam int PEXT_W = (IDX_W > POS_W) ? IDX_W : POS_W;
    localparam int CEXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    logic [KEY_W-1:0]        keys_reg [SET_CAPACITY];
    logic [KEY_W-1:0]        key_reg;
    logic [CMD_W-1:0]        cmd_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [SET_CAPACITY-1:0] hit_vec_reg;
    logic [SET_CAPACITY-1:0] hit_vec_next;

    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    logic                    found_reg;
    logic [POS_W-1:0]        position_reg;
    logic [COUNT_W-1:0]      count_out_reg;
    status_t                 status_reg;
    status_t                 status_next;

    logic                    hit;
    logic [IDX_W-1:0]        pos_idx;
    logic                    add_ok;
    logic                    rem_ok;
    logic [PEXT_W-1:0]       pos_ext;
    logic [CEXT_W-1:0]       cnt_ext;

    always_comb
    begin
        for (int i = 0; i < SET_CAPACITY; i++)
        begin
            hit_vec_next[i] = (keys_reg[i] == key_reg) && (CNT_W'(i) < count_reg);
        end
    end

    // keys are unique, so at most one match bit is set
    always_comb
    begin
        pos_idx = '0;
        for (int i = 0; i < SET_CAPACITY; i++)
        begin
            pos_idx = pos_idx | (hit_vec_reg[i] ? IDX_W'(i) : IDX_W'(0));
        end
        hit    = |hit_vec_reg;
        add_ok = (cmd_reg == CMD_ADD) && !hit && (count_reg < CNT_W'(SET_CAPACITY));
        rem_ok = (cmd_reg == CMD_REMOVE) && hit;
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl_cmd.do_apply && add_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl_cmd.do_apply && rem_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        case (cmd_reg)
            CMD_ADD:
            begin
                if (hit)
                begin
                    status_next = ST_DUPLICATE;
                end
                else if (!add_ok)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_DONE;
                end
            end
            default:
            begin
                status_next = hit ? ST_DONE : ST_ABSENT;
            end
        endcase
    end

    always_comb
    begin
        pos_ext = PEXT_W'(pos_idx);
        cnt_ext = CEXT_W'(count_next);
    end

    always_comb
    begin
        dp_status.out_free = !rsp_valid_reg || !rsp_stall;
        rsp_valid_next     = rsp_valid_reg && rsp_stall;
        if (ctl_cmd.do_apply)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    // append on add, shift the tail down one place on remove
    for (genvar g = 0; g < SET_CAPACITY; g++)
    begin : g_entry
        always_ff @(posedge clk)
        begin
            if (ctl_cmd.do_apply && add_ok && (count_reg == CNT_W'(g)))
            begin
                keys_reg[g] <= key_reg;
            end
            else if (ctl_cmd.do_apply && rem_ok && (IDX_W'(g) >= pos_idx))
            begin
                if (g < SET_CAPACITY - 1)
                begin
                    keys_reg[g] <= keys_reg[(g + 1) % SET_CAPACITY];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_cmd.load_item)
        begin
            key_reg <= key;
            cmd_reg <= cmd;
        end
        if (ctl_cmd.do_apply)
        begin
            found_reg     <= hit;
            position_reg  <= pos_ext[POS_W-1:0];
            count_out_reg <= cnt_ext[COUNT_W-1:0];
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            hit_vec_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (ctl_cmd.do_search)
            begin
                hit_vec_reg <= hit_vec_next;
            end
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign found       = found_reg;
    assign position    = position_reg;
    assign entry_count = count_out_reg;
    assign status      = status_reg;

    `OST_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(SET_CAPACITY))
    `OST_ASSERT_SAME(a_unique_match, 1'b1, $onehot0(hit_vec_reg))
    `OST_ASSERT_SAME(a_full_at_cap, rsp_valid_reg && (status_reg == ST_FULL),
        count_reg == CNT_W'(SET_CAPACITY))
    `OST_ASSERT_NEXT(a_remove_shrinks, ctl_cmd.do_apply && rem_ok,
        count_reg == $past(count_reg) - CNT_W'(1))

endmodule

### hdl/ordered_set_table_unit.sv
// ============================================================================
// Ordered set table unit
// Fixed-capacity set of 32-bit keys in insertion order with add, remove and
// lookup commands; remove compacts the stored keys.
// ============================================================================
//
//   channel   handshake              payload
//   command   cmd_valid / cmd_stall  cmd, key
//   response  rsp_valid / rsp_stall  found, position, entry_count, status
//
// Per command, a registered parallel match over all entries, then an update
// step that appends or shifts the tail down one place and accepts the next.
// Reset clears the entry count; stored keys hold no reset value.
// A stalled response holds in the output register while the next command
// is searched; the update step waits while the response is still stalled.
//
module ordered_set_table_unit
    import ost_pkg::*;
#(
    parameter int SET_CAPACITY = OST_SET_CAPACITY
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_stall,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [KEY_W-1:0]  key,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic                     found,
    output logic [POS_W-1:0]         position,
    output logic [COUNT_W-1:0]       entry_count,
    output logic [STATUS_W-1:0]      status
);

    ctl_cmd_t   ctl_cmd;
    dp_status_t dp_status;

    ost_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .dp_status (dp_status),
        .ctl_cmd   (ctl_cmd)
    );

    ost_datapath #(
        .SET_CAPACITY (SET_CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl_cmd     (ctl_cmd),
        .dp_status   (dp_status),
        .cmd         (cmd),
        .key         (key),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .found       (found),
        .position    (position),
        .entry_count (entry_count),
        .status      (status)
    );

endmodule
